FILE: rtl/rsp_pkg.sv
// shared types and constants of the region stream prefetcher
package rsp_pkg;

    // configuration registers
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_DEPTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] DEPTH_RESET  = 7'd4;
    localparam logic [CFG_W-1:0] THRESH_RESET = 7'd2;

    // lookup command broadcast to every table cell
    typedef struct packed {
        logic en;        // update the table this cycle
        logic hit;       // the accessed region is tracked
        logic has_up;    // next region up is tracked
        logic has_down;  // next region down is tracked
    } t_cell_cmd;

    // match flags reported by a table cell
    typedef struct packed {
        logic tag_hit;
        logic up_hit;
        logic down_hit;
        logic lru;
    } t_cell_flags;

    // updated entry state of the selected cell
    typedef struct packed {
        logic sel;
        logic act;
        logic desc;
    } t_cell_res;

endpackage

FILE: rtl/rsp_access_if.sv
// demand access channel
interface rsp_access_if #(
    parameter int ADDRESS_BITS = 48
);
    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

FILE: rtl/rsp_prefetch_if.sv
// prefetch request channel
interface rsp_prefetch_if #(
    parameter int ADDRESS_BITS = 48
);
    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] prefetch_address;

    modport source (output valid, output prefetch_address, input ready);
    modport sink   (input valid, input prefetch_address, output ready);
endinterface

FILE: rtl/region_stream_prefetcher.sv
// region stream prefetcher: region table of cells, filter chain, output register
// latency: a transfer in is held in stage a, where it is looked up and the table updated;
// stage b holds its candidate for the filter, and an emitted prefetch is registered in the output register
// throughput: one access per cycle, set by the table update loop, while the prefetch output does not stall
// reset: synchronous active low; table empty, ranks in index order, filter empty,
// prefetch_depth 4, active_threshold 2; no clearing pass
module region_stream_prefetcher #(
    parameter int TABLE_ENTRIES  = 16,
    parameter int FILTER_ENTRIES = 32,
    parameter int BLOCK_BYTES    = 64,
    parameter int REGION_BLOCKS  = 64,
    parameter int ADDRESS_BITS   = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rsp_pkg::CFG_W-1:0]     i_cfg_data,
    rsp_access_if.sink                    i_access,
    rsp_prefetch_if.source                o_prefetch
);
    import rsp_pkg::*;

    // address split
    localparam int OB    = $clog2(BLOCK_BYTES);
    localparam int OFF_W = $clog2(REGION_BLOCKS);
    localparam int TAG_W = ADDRESS_BITS - OB - OFF_W;
    localparam int FB_W  = ADDRESS_BITS - OB;
    localparam int CNT_W = $clog2(REGION_BLOCKS + 1);
    localparam int RK_W  = $clog2(TABLE_ENTRIES);

    localparam logic [RK_W-1:0] RANK_LAST = RK_W'(TABLE_ENTRIES - 1);

    // configuration registers
    logic [CFG_W-1:0] r_depth;
    logic [CFG_W-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= DEPTH_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PREFETCH_DEPTH:   r_depth  <= i_cfg_data;
                REG_ACTIVE_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline registers
    logic                    r_a_vld;
    logic [ADDRESS_BITS-1:0] r_a_addr;
    logic                    r_b_vld;
    logic                    r_b_act;
    logic [FB_W-1:0]         r_b_cand;
    logic                    r_o_vld;
    logic [ADDRESS_BITS-1:0] r_o_addr;

    logic out_free, b_go, b_emit, b_free, a_go, in_xfer, f_hit;

    // table stage: lookup key of the access held in stage a
    logic [TAG_W-1:0] a_tag, a_up, a_down;
    logic [OFF_W-1:0] a_off;
    logic [FB_W-1:0]  a_blk;

    assign a_tag  = r_a_addr[ADDRESS_BITS-1 -: TAG_W];
    assign a_up   = a_tag + 1'b1;       // wraps to region zero
    assign a_down = a_tag - 1'b1;       // wraps to the highest region
    assign a_off  = r_a_addr[OB +: OFF_W];
    assign a_blk  = r_a_addr[ADDRESS_BITS-1:OB];

    t_cell_flags            cell_flags [TABLE_ENTRIES];
    t_cell_res              cell_res   [TABLE_ENTRIES];
    logic [RK_W-1:0]        cell_rank  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] tag_hits, lru_vec;
    t_cell_cmd              cmd;
    logic [RK_W-1:0]        rank_sel;
    logic                   e_act, e_desc;
    logic [FB_W-1:0]        cand;

    always_comb begin
        logic any_up;
        logic any_down;
        logic [RK_W-1:0] hit_rank;
        any_up   = 1'b0;
        any_down = 1'b0;
        hit_rank = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            tag_hits[k] = cell_flags[k].tag_hit;
            lru_vec[k]  = cell_flags[k].lru;
            any_up      = any_up | cell_flags[k].up_hit;
            any_down    = any_down | cell_flags[k].down_hit;
            hit_rank    = hit_rank | (cell_flags[k].tag_hit ? cell_rank[k] : '0);
        end
        cmd.en       = a_go;
        cmd.hit      = |tag_hits;
        cmd.has_up   = any_up;
        cmd.has_down = any_down;
        // on a miss the victim holds the last rank
        rank_sel     = cmd.hit ? hit_rank : RANK_LAST;
    end

    // state of the entry after this access
    always_comb begin
        e_act  = 1'b0;
        e_desc = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            e_act  = e_act | (cell_res[k].sel & cell_res[k].act);
            e_desc = e_desc | (cell_res[k].sel & cell_res[k].desc);
        end
    end

    assign cand = e_desc ? (a_blk - FB_W'(r_depth)) : (a_blk + FB_W'(r_depth));

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_table
        rsp_table_cell #(
            .IDX     (g),
            .ENTRIES (TABLE_ENTRIES),
            .TAG_W   (TAG_W),
            .MAP_W   (REGION_BLOCKS),
            .OFF_W   (OFF_W),
            .CNT_W   (CNT_W),
            .RK_W    (RK_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tag      (a_tag),
            .i_up       (a_up),
            .i_down     (a_down),
            .i_off      (a_off),
            .i_cmd      (cmd),
            .i_rank_sel (rank_sel),
            .i_thresh   (r_thresh),
            .o_flags    (cell_flags[g]),
            .o_res      (cell_res[g]),
            .o_rank     (cell_rank[g])
        );
    end

    // filter chain: a new prefetch enters cell zero, the oldest drops off the end
    logic            chain_vld [FILTER_ENTRIES];
    logic [FB_W-1:0] chain_blk [FILTER_ENTRIES];
    logic [FILTER_ENTRIES-1:0] f_match;

    for (genvar g = 0; g < FILTER_ENTRIES; g++) begin : g_filter
        rsp_filter_cell #(
            .FB_W (FB_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (b_emit),
            .i_vld   ((g == 0) ? 1'b1 : chain_vld[(g == 0) ? 0 : g - 1]),
            .i_blk   ((g == 0) ? r_b_cand : chain_blk[(g == 0) ? 0 : g - 1]),
            .i_cand  (r_b_cand),
            .o_vld   (chain_vld[g]),
            .o_blk   (chain_blk[g]),
            .o_match (f_match[g])
        );
    end

    assign f_hit = |f_match;

    // flow control
    assign out_free        = !r_o_vld || o_prefetch.ready;
    assign b_emit          = r_b_vld && r_b_act && !f_hit && out_free;
    assign b_go            = r_b_vld && (!r_b_act || f_hit || out_free);
    assign b_free          = !r_b_vld || b_go;
    assign a_go            = r_a_vld && b_free;
    assign i_access.ready  = !r_a_vld || b_free;
    assign in_xfer         = i_access.valid && i_access.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_a_vld <= 1'b1;
            end else if (a_go) begin
                r_a_vld <= 1'b0;
            end
            if (a_go) begin
                r_b_vld <= 1'b1;
            end else if (b_go) begin
                r_b_vld <= 1'b0;
            end
            if (b_emit) begin
                r_o_vld <= 1'b1;
            end else if (o_prefetch.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_addr <= i_access.access_address;
        end
        if (a_go) begin
            r_b_act  <= e_act;
            r_b_cand <= cand;
        end
        if (b_emit) begin
            r_o_addr <= {r_b_cand, OB'(0)};
        end
    end

    assign o_prefetch.valid            = r_o_vld;
    assign o_prefetch.prefetch_address = r_o_addr;

    // a region is tracked by at most one entry
    a_tag_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tag_hits))
        else $error("region tracked twice");

    // ranks stay a permutation, so exactly one entry is least recent
    a_one_lru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(lru_vec))
        else $error("no unique lru entry");

    // a new prefetch only comes from an active item leaving the filter stage
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> $past(r_b_vld && r_b_act && !f_hit))
        else $error("prefetch without a filtered candidate");

endmodule

FILE: rtl/rsp_table_cell.sv
// one entry of the region tracking table
module rsp_table_cell #(
    parameter int IDX     = 0,
    parameter int ENTRIES = 16,
    parameter int TAG_W   = 36,
    parameter int MAP_W   = 64,
    parameter int OFF_W   = 6,
    parameter int CNT_W   = 7,
    parameter int RK_W    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [TAG_W-1:0]          i_up,
    input  logic [TAG_W-1:0]          i_down,
    input  logic [OFF_W-1:0]          i_off,
    input  rsp_pkg::t_cell_cmd        i_cmd,
    input  logic [RK_W-1:0]           i_rank_sel,
    input  logic [rsp_pkg::CFG_W-1:0] i_thresh,
    output rsp_pkg::t_cell_flags      o_flags,
    output rsp_pkg::t_cell_res        o_res,
    output logic [RK_W-1:0]           o_rank
);
    import rsp_pkg::*;

    localparam logic [RK_W-1:0] RANK_LAST = RK_W'(ENTRIES - 1);

    logic             r_vld, n_vld;
    logic [RK_W-1:0]  r_rank, n_rank;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [MAP_W-1:0] r_map, n_map;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_act, n_act;
    logic             r_desc, n_desc;
    logic             sel;
    logic [MAP_W-1:0] bit_mask;

    assign o_flags.tag_hit  = r_vld && (r_tag == i_tag);
    assign o_flags.up_hit   = r_vld && (r_tag == i_up);
    assign o_flags.down_hit = r_vld && (r_tag == i_down);
    assign o_flags.lru      = (r_rank == RANK_LAST);
    assign sel              = i_cmd.hit ? o_flags.tag_hit : o_flags.lru;
    assign bit_mask         = MAP_W'(1) << i_off;
    assign o_rank           = r_rank;
    assign o_res.sel        = sel;
    assign o_res.act        = n_act;
    assign o_res.desc       = n_desc;

    always_comb begin
        n_vld  = r_vld;
        n_tag  = r_tag;
        n_map  = r_map;
        n_cnt  = r_cnt;
        n_act  = r_act;
        n_desc = r_desc;
        n_rank = r_rank;
        if (sel) begin
            n_rank = '0;
        end else if (r_rank < i_rank_sel) begin
            n_rank = r_rank + 1'b1;
        end
        if (sel && i_cmd.hit) begin
            n_desc = r_desc | i_cmd.has_up;
            n_act  = r_act | i_cmd.has_up | i_cmd.has_down
                     | (CFG_W'(r_cnt) > i_thresh);
            if ((r_map & bit_mask) == '0) begin
                n_map = r_map | bit_mask;
                n_cnt = r_cnt + 1'b1;
            end
        end else if (sel) begin
            n_vld  = 1'b1;
            n_tag  = i_tag;
            n_map  = bit_mask;
            n_cnt  = CNT_W'(1);
            n_desc = i_cmd.has_up;
            n_act  = i_cmd.has_up | i_cmd.has_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_rank <= RK_W'(IDX);
        end else if (i_cmd.en) begin
            r_vld  <= n_vld;
            r_rank <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_tag  <= n_tag;
            r_map  <= n_map;
            r_cnt  <= n_cnt;
            r_act  <= n_act;
            r_desc <= n_desc;
        end
    end

endmodule

FILE: rtl/rsp_filter_cell.sv
// one stage of the recent prefetch filter shift chain
module rsp_filter_cell #(
    parameter int FB_W = 42
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_vld,
    input  logic [FB_W-1:0] i_blk,
    input  logic [FB_W-1:0] i_cand,
    output logic            o_vld,
    output logic [FB_W-1:0] o_blk,
    output logic            o_match
);
    logic            r_vld;
    logic [FB_W-1:0] r_blk;

    assign o_vld   = r_vld;
    assign o_blk   = r_blk;
    assign o_match = r_vld && (r_blk == i_cand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_blk <= i_blk;
        end
    end

endmodule

FILE: sim/region_stream_prefetcher_tb.sv
// self-checking testbench of the region stream prefetcher
`timescale 1ns / 1ps

module region_stream_prefetcher_tb;
    import rsp_pkg::*;

    localparam int ADDR_W      = 48;
    localparam int TAG_W       = 36;
    localparam int BLK_W       = 42;
    localparam int N_REGIONS   = 16;
    localparam int N_FILTER    = 32;
    localparam int WATCHDOG    = 3000;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 400;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 308;

    typedef enum logic {ROW_ACCESS, ROW_CONFIG} t_row_kind;

    // one directed step: an access (expected result typed in or predicted) or a register write
    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_W-1:0]        val;
        logic [ADDR_W-1:0]       addr;
        logic                    typed;
        logic [ADDR_W-1:0]       want;
    } t_row;

    localparam int N_ROWS = 24;
    localparam t_row ROWS [N_ROWS] = '{
        // empty table, no neighbours: no prefetch
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_1000, 1'b0, 48'h0},
        // region zero with region one above: descending, wraps below zero
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_0000, 1'b1, 48'hFFFF_FFFF_FF00},
        // highest region, region zero is the neighbour above
        '{ROW_ACCESS, 1'b0, 7'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FEC0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_0000, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_0040, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_1040, 1'b0, 48'h0},
        // isolated region goes active on its count
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5000, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5040, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_50C0, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5100, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5100, 1'b0, 48'h0},
        // zero depth names the accessed block
        '{ROW_CONFIG, REG_PREFETCH_DEPTH, 7'd0, 48'h0, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5140, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_5180, 1'b0, 48'h0},
        // depth 64, threshold zero
        '{ROW_CONFIG, REG_PREFETCH_DEPTH, 7'd64, 48'h0, 1'b0, 48'h0},
        '{ROW_CONFIG, REG_ACTIVE_THRESHOLD, 7'd0, 48'h0, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_9000, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h0000_0000_9040, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'hFFFF_FFFF_F000, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'hFFFF_FFFF_F7C0, 1'b0, 48'h0},
        // threshold 64, depth one
        '{ROW_CONFIG, REG_ACTIVE_THRESHOLD, 7'd64, 48'h0, 1'b0, 48'h0},
        '{ROW_CONFIG, REG_PREFETCH_DEPTH, 7'd1, 48'h0, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'h5555_5555_5555, 1'b0, 48'h0},
        '{ROW_ACCESS, 1'b0, 7'd0, 48'hAAAA_AAAA_AAAA, 1'b0, 48'h0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    rsp_access_if   #(.ADDRESS_BITS(ADDR_W)) access_ch ();
    rsp_prefetch_if #(.ADDRESS_BITS(ADDR_W)) prefetch_ch ();

    region_stream_prefetcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_access    (access_ch.sink),
        .o_prefetch  (prefetch_ch.source)
    );

    // clock, 8 ns period
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of configuration and table state
    logic [CFG_W-1:0]   depth_q;
    logic [CFG_W-1:0]   thresh_q;
    logic               rg_valid  [N_REGIONS];
    logic [TAG_W-1:0]   rg_tag    [N_REGIONS];
    logic [63:0]        rg_map    [N_REGIONS];
    logic [6:0]         rg_count  [N_REGIONS];
    logic               rg_active [N_REGIONS];
    logic               rg_desc   [N_REGIONS];
    int unsigned        rg_rank   [N_REGIONS];
    logic [BLK_W-1:0]   flt_blk   [N_FILTER];
    logic               flt_valid [N_FILTER];
    int unsigned        flt_wp;

    logic [ADDR_W-1:0] pending_prefetches [$];
    int  mismatches;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  prefetches_seen;
    int  quiet_cycles;

    function automatic int lookup_region(input logic [TAG_W-1:0] t);
        for (int i = 0; i < N_REGIONS; i++)
            if (rg_valid[i] && rg_tag[i] == t)
                return i;
        return -1;
    endfunction

    // move entry to rank zero, everything more recent ages by one
    function automatic void promote(input int e);
        int unsigned r;
        r = rg_rank[e];
        for (int i = 0; i < N_REGIONS; i++)
            if (rg_rank[i] < r)
                rg_rank[i]++;
        rg_rank[e] = 0;
    endfunction

    // trains on one access; returns 1 with the prefetch address when one is issued
    function automatic bit train_on_access(input logic [ADDR_W-1:0] a,
                                           output logic [ADDR_W-1:0] pf);
        logic [TAG_W-1:0] tag;
        logic [5:0]       off;
        logic [BLK_W-1:0] blk;
        logic [BLK_W-1:0] pblk;
        bit               has_up;
        bit               has_down;
        int               e;
        tag = a[47:12];
        off = a[11:6];
        blk = a[47:6];
        has_up   = lookup_region(tag + 1'b1) >= 0;
        has_down = lookup_region(tag - 1'b1) >= 0;
        e = lookup_region(tag);
        pf = '0;
        if (e >= 0) begin
            promote(e);
            if (has_up)
                rg_desc[e] = 1'b1;
            if (has_up || has_down || rg_count[e] > thresh_q)
                rg_active[e] = 1'b1;
            if (!rg_map[e][off]) begin
                rg_map[e][off] = 1'b1;
                rg_count[e]++;
            end
        end else begin
            e = 0;
            for (int i = 1; i < N_REGIONS; i++)
                if (rg_rank[i] > rg_rank[e])
                    e = i;
            promote(e);
            rg_valid[e]  = 1'b1;
            rg_tag[e]    = tag;
            rg_map[e]    = 64'd1 << off;
            rg_count[e]  = 7'd1;
            rg_desc[e]   = has_up;
            rg_active[e] = has_up || has_down;
        end
        if (!rg_active[e])
            return 1'b0;
        pblk = rg_desc[e] ? blk - BLK_W'(depth_q) : blk + BLK_W'(depth_q);
        for (int i = 0; i < N_FILTER; i++)
            if (flt_valid[i] && flt_blk[i] == pblk)
                return 1'b0;
        flt_blk[flt_wp]   = pblk;
        flt_valid[flt_wp] = 1'b1;
        flt_wp = (flt_wp + 1) % N_FILTER;
        pf = {pblk, 6'd0};
        return 1'b1;
    endfunction

    // wait until every prefetch has come out, then let the pipeline settle
    task automatic drain_pipeline();
        while (pending_prefetches.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // register write while idle; called at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_pipeline();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_PREFETCH_DEPTH)
            depth_q = val;
        else
            thresh_q = val;
    endtask

    // offers one access; returns at the falling edge after the transfer
    task automatic send_access(input logic [ADDR_W-1:0] a, input bit typed,
                               input logic [ADDR_W-1:0] want);
        logic [ADDR_W-1:0] pf;
        bit                issued;
        while ($urandom_range(99) < snd_idle_pct) begin
            access_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        access_ch.valid          = 1'b1;
        access_ch.access_address = a;
        do @(posedge i_clk); while (!access_ch.ready);
        issued = train_on_access(a, pf);
        if (typed)
            pending_prefetches = {pending_prefetches, want};
        else if (issued)
            pending_prefetches = {pending_prefetches, pf};
        @(negedge i_clk);
        access_ch.valid = 1'b0;
    endtask

    // random stimulus: mostly short block streams over a cluster of neighbouring
    // regions so that regions go active and the filter sees repeats
    task automatic run_random_phase(input int count);
        logic [TAG_W-1:0]  base_tag;
        logic [BLK_W-1:0]  stream_blk;
        logic [ADDR_W-1:0] a;
        bit                down_dir;
        int                r;
        base_tag   = TAG_W'({$urandom, $urandom});
        stream_blk = {base_tag, 6'($urandom)};
        down_dir   = 1'($urandom_range(1));
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                stream_blk = {base_tag + TAG_W'($urandom_range(24)), 6'($urandom)};
                down_dir   = 1'($urandom_range(1));
            end
            if (r < 70) begin
                stream_blk = down_dir ? stream_blk - BLK_W'($urandom_range(1, 3))
                                      : stream_blk + BLK_W'($urandom_range(1, 3));
                a = {stream_blk, 6'($urandom)};
            end else if (r < 88) begin
                a = {base_tag + TAG_W'($urandom_range(24)), 12'($urandom)};
            end else begin
                a = ADDR_W'({$urandom, $urandom});
            end
            send_access(a, 1'b0, '0);
        end
    endtask

    // receiver: random stalls plus one long hold-off that fills the block
    int  hold_left;
    bit  hold_done;
    always @(negedge i_clk) begin
        if (!hold_done && prefetches_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            prefetch_ch.ready = 1'b0;
        end else begin
            prefetch_ch.ready = $urandom_range(99) >= rcv_idle_pct;
        end
    end

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        logic [ADDR_W-1:0] want;
        if (i_rst_n && prefetch_ch.valid && prefetch_ch.ready) begin
            prefetches_seen++;
            if (pending_prefetches.size() == 0) begin
                $display("%0t: unexpected prefetch transfer, expected none, actual %h",
                         $time, prefetch_ch.prefetch_address);
                mismatches++;
            end else begin
                want = pending_prefetches.pop_front();
                if (prefetch_ch.prefetch_address !== want) begin
                    $display("%0t: prefetch_address mismatch, expected %h, actual %h",
                             $time, want, prefetch_ch.prefetch_address);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((access_ch.valid && access_ch.ready) || (prefetch_ch.valid && prefetch_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // phase settings: depth, threshold
    localparam logic [CFG_W-1:0] PH_DEPTH  [N_PHASES] = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd17, 7'd8};
    localparam logic [CFG_W-1:0] PH_THRESH [N_PHASES] = '{7'd2, 7'd0, 7'd64, 7'd5, 7'd3, 7'd1};

    initial begin
        // every input known from time zero
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_index              = REG_PREFETCH_DEPTH;
        i_cfg_data               = '0;
        access_ch.valid          = 1'b0;
        access_ch.access_address = '0;
        prefetch_ch.ready        = 1'b0;
        mismatches      = 0;
        prefetches_seen = 0;
        quiet_cycles    = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        snd_idle_pct    = 32;
        rcv_idle_pct    = 71;
        depth_q  = DEPTH_RESET;
        thresh_q = THRESH_RESET;
        flt_wp   = 0;
        for (int i = 0; i < N_REGIONS; i++) begin
            rg_valid[i]  = 1'b0;
            rg_tag[i]    = '0;
            rg_map[i]    = '0;
            rg_count[i]  = '0;
            rg_active[i] = 1'b0;
            rg_desc[i]   = 1'b0;
            rg_rank[i]   = i;
        end
        for (int i = 0; i < N_FILTER; i++) begin
            flt_blk[i]   = '0;
            flt_valid[i] = 1'b0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table straight after reset
        for (int i = 0; i < N_ROWS; i++) begin
            if (ROWS[i].kind == ROW_CONFIG)
                write_reg(ROWS[i].idx, ROWS[i].val);
            else
                send_access(ROWS[i].addr, ROWS[i].typed, ROWS[i].want);
        end

        // random phases: receiver idles more first, sender more next, then no idling
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_PREFETCH_DEPTH, PH_DEPTH[p]);
            write_reg(REG_ACTIVE_THRESHOLD, PH_THRESH[p]);
            snd_idle_pct = (p < 2) ? 32 : (p < 4) ? 71 : 0;
            rcv_idle_pct = (p < 2) ? 71 : (p < 4) ? 32 : 0;
            run_random_phase(PHASE_ITEMS);
        end

        drain_pipeline();
        if (mismatches == 0 && pending_prefetches.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: region_stream_prefetcher.f
rtl/rsp_pkg.sv
rtl/rsp_access_if.sv
rtl/rsp_prefetch_if.sv
rtl/rsp_table_cell.sv
rtl/rsp_filter_cell.sv
rtl/region_stream_prefetcher.sv
sim/region_stream_prefetcher_tb.sv
